// File: src/srr_pkg.sv
// Shared types and constants for the serial packet receive ring.
package srr_pkg;

  localparam int FILL_W     = 9;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int RLEN_W     = 7;
  localparam int PKT_CNT_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH = 1'b1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h0A;
  localparam logic [LEN_W-1:0]  PKT_LEN_RST    = 5'd8;
  localparam logic [LEN_W-1:0]  PKT_LEN_MIN    = 5'd2;
  localparam logic [LEN_W-1:0]  PKT_LEN_MAX    = 5'd16;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic take_read;
    logic pop;
  } srr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic req_rd;
    logic rlen_zero;
    logic last_pop;
  } srr_sts_t;

endpackage

// File: src/serial_packet_receive_ring_core.sv
// Top level of the serial packet receive ring: framer plus circular byte store.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------------
//  in      | input     | in_valid / in_stall | in_req_type, in_rx_byte, in_read_length
//  out     | output    | out_valid/out_stall | out_read_data, out_read_valid, out_last,
//          |           |                     | out_fill_level, out_packets_done, out_dropped
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// A received byte or an empty read is one transfer in and one result out, one per cycle
// while the result register drains. A read of N bytes holds off input until its last byte
// is popped and emits one byte per cycle while unstalled, paced by the registered store read port.
// Reset (rst_n low, synchronous) clears pointers, counters and the framer; store contents
// stay undefined and need no clearing. out_stall freezes the result register and input.
module serial_packet_receive_ring_core
  import srr_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  input  logic [RLEN_W-1:0]     in_read_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_read_data,
  output logic                  out_read_valid,
  output logic                  out_last,
  output logic [FILL_W-1:0]     out_fill_level,
  output logic [PKT_CNT_W-1:0]  out_packets_done,
  output logic                  out_dropped
);

  srr_cmd_t cmd;
  srr_sts_t sts;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srr_dp #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .in_read_length   (in_read_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid),
    .out_last         (out_last),
    .out_fill_level   (out_fill_level),
    .out_packets_done (out_packets_done),
    .out_dropped      (out_dropped),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// File: src/srr_ctrl.sv
// Controller: accepts items and sequences read bursts.
module srr_ctrl
  import srr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  srr_sts_t sts,
  output srr_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_take;

  always_comb begin
    in_stall      = !(state_r == ST_IDLE && sts.out_free);
    in_take       = in_valid && !in_stall;
    cmd.take_byte = in_take && !sts.req_rd;
    cmd.take_read = in_take && sts.req_rd;
    cmd.pop       = (state_r == ST_READ) && sts.out_free;
    state_nxt     = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.take_read && !sts.rlen_zero) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (cmd.pop && sts.last_pop) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/srr_dp.sv
// Datapath: framer, circular byte store, counters and result register.
module srr_dp
  import srr_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_req_type,
  input  logic [BYTE_W-1:0]       in_rx_byte,
  input  logic [RLEN_W-1:0]       in_read_length,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BYTE_W-1:0]       out_read_data,
  output logic                    out_read_valid,
  output logic                    out_last,
  output logic [FILL_W-1:0]       out_fill_level,
  output logic [PKT_CNT_W-1:0]    out_packets_done,
  output logic                    out_dropped,
  input  srr_cmd_t                cmd,
  output srr_sts_t                sts
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(MAX_READ + 1);

  logic [BYTE_W-1:0]    mem [DEPTH];
  logic [BYTE_W-1:0]    rdata_r;

  logic [BYTE_W-1:0]    start_byte_r;
  logic [LEN_W-1:0]     pkt_len_r;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [LEN_W-1:0]     need_r, need_nxt;
  logic [PKT_CNT_W-1:0] pkt_cnt_r, pkt_cnt_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_data_r, out_data_nxt;
  logic                 out_rv_r, out_rv_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [FILL_W-1:0]    out_fill_r, out_fill_nxt;
  logic [PKT_CNT_W-1:0] out_pkts_r, out_pkts_nxt;
  logic                 out_drop_r, out_drop_nxt;

  logic [LEN_W-1:0]     eff_len;
  logic                 hunting;
  logic                 full;
  logic                 wr_en;
  logic [RLEN_W-1:0]    cap_len;
  logic [FILL_W-1:0]    rlen;
  logic [LEN_W-1:0]     need_dec;
  logic [PW-1:0]        rd_addr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    if (pkt_len_r < PKT_LEN_MIN)      eff_len = PKT_LEN_MIN;
    else if (pkt_len_r > PKT_LEN_MAX) eff_len = PKT_LEN_MAX;
    else                              eff_len = pkt_len_r;
    hunting  = (need_r == '0) || (need_r >= eff_len);
    full     = (count_r == CW'(DEPTH));
    need_dec = need_r - LEN_W'(1);
    cap_len  = (in_read_length > RLEN_W'(MAX_READ)) ? RLEN_W'(MAX_READ) : in_read_length;
    rlen     = (FILL_W'(cap_len) < FILL_W'(count_r)) ? FILL_W'(cap_len) : FILL_W'(count_r);

    sts.out_free  = !out_valid_r || !out_stall;
    sts.req_rd    = in_req_type;
    sts.rlen_zero = (rlen == '0);
    sts.last_pop  = (rem_r == RW'(1));

    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    need_nxt      = need_r;
    pkt_cnt_nxt   = pkt_cnt_r;
    rem_nxt       = rem_r;
    wr_en         = 1'b0;

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_rv_nxt    = out_rv_r;
    out_last_nxt  = out_last_r;
    out_fill_nxt  = out_fill_r;
    out_pkts_nxt  = out_pkts_r;
    out_drop_nxt  = out_drop_r;

    if (cmd.take_byte) begin
      out_drop_nxt = 1'b0;
      if (hunting) begin
        need_nxt = (in_rx_byte == start_byte_r) ? eff_len - LEN_W'(1) : eff_len;
      end else if (!full) begin
        wr_en      = 1'b1;
        wr_ptr_nxt = ptr_inc(wr_ptr_r);
        count_nxt  = count_r + CW'(1);
        if (need_dec == '0) begin
          pkt_cnt_nxt = pkt_cnt_r + PKT_CNT_W'(1);
          need_nxt    = eff_len;
        end else begin
          need_nxt = need_dec;
        end
      end else begin
        out_drop_nxt = 1'b1;
      end
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_rv_nxt    = 1'b0;
      out_last_nxt  = 1'b1;
      out_fill_nxt  = FILL_W'(count_nxt);
      out_pkts_nxt  = pkt_cnt_nxt;
    end

    if (cmd.take_read) begin
      rem_nxt = RW'(rlen);
      if (rlen == '0) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_rv_nxt    = 1'b0;
        out_last_nxt  = 1'b1;
        out_fill_nxt  = FILL_W'(count_r);
        out_pkts_nxt  = pkt_cnt_r;
        out_drop_nxt  = 1'b0;
      end
    end

    if (cmd.pop) begin
      rd_ptr_nxt    = ptr_inc(rd_ptr_r);
      count_nxt     = count_r - CW'(1);
      rem_nxt       = rem_r - RW'(1);
      out_valid_nxt = 1'b1;
      out_data_nxt  = rdata_r;
      out_rv_nxt    = 1'b1;
      out_last_nxt  = sts.last_pop;
      out_fill_nxt  = FILL_W'(count_nxt);
      out_pkts_nxt  = pkt_cnt_r;
      out_drop_nxt  = 1'b0;
    end

    // rdata_r is loaded from the entry at the next read pointer
    rd_addr = rd_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= in_rx_byte;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      pkt_len_r    <= PKT_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:    start_byte_r <= cfg_wdata;
        CFG_PACKET_LENGTH: pkt_len_r    <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      need_r      <= PKT_LEN_RST;
      pkt_cnt_r   <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      need_r      <= need_nxt;
      pkt_cnt_r   <= pkt_cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_rv_r   <= out_rv_nxt;
    out_last_r <= out_last_nxt;
    out_fill_r <= out_fill_nxt;
    out_pkts_r <= out_pkts_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_read_valid   = out_rv_r;
  assign out_last         = out_last_r;
  assign out_fill_level   = out_fill_r;
  assign out_packets_done = out_pkts_r;
  assign out_dropped      = out_drop_r;

endmodule

// File: src/srr_chk.sv
// Port-level checker for the serial packet receive ring, with its bind.
module srr_chk
  import srr_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [BYTE_W-1:0]    out_read_data,
  input logic                 out_read_valid,
  input logic                 out_last,
  input logic [FILL_W-1:0]    out_fill_level,
  input logic                 out_dropped
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_last))
    else $error("result changed while stalled");

  // a result without data is the only result of its item and carries zero
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_last && (out_read_data == '0))
    else $error("result without data is not a lone zero result");

  // a drop flag only comes with a received byte into a full store, never with popped data
  a_drop_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_read_valid && (out_fill_level == FILL_W'(DEPTH)))
    else $error("drop flagged on a data result or with store not full");

  // fill level never exceeds the store
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_level <= FILL_W'(DEPTH))
    else $error("fill level out of range");

endmodule

bind serial_packet_receive_ring_core srr_chk #(
  .DEPTH (DEPTH)
) u_srr_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_read_valid (out_read_valid),
  .out_last       (out_last),
  .out_fill_level (out_fill_level),
  .out_dropped    (out_dropped)
);

// File: bench/serial_packet_receive_ring_core_tb.sv
`timescale 1ns / 100ps
// Testbench for serial_packet_receive_ring_core: framed byte capture and ring readout.
module serial_packet_receive_ring_core_tb;
  import srr_pkg::*;

  localparam int RING_DEPTH   = 256;
  localparam int READ_CAP     = 64;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct {
    logic [BYTE_W-1:0]    data;
    logic                 valid;
    logic                 last;
    logic [FILL_W-1:0]    fill;
    logic [PKT_CNT_W-1:0] pkts;
    logic                 dropped;
  } ring_result_t;

  class ring_scoreboard;
    logic [BYTE_W-1:0]    start_val;
    logic [LEN_W-1:0]     len_reg;
    logic [BYTE_W-1:0]    ring [RING_DEPTH];
    int unsigned          rd_ptr;
    int unsigned          wr_ptr;
    int unsigned          count;
    int unsigned          need;
    logic [PKT_CNT_W-1:0] pkt_cnt;
    ring_result_t         due_q[$];
    int unsigned          mismatches;

    function void clear();
      start_val = START_BYTE_RST;
      len_reg   = PKT_LEN_RST;
      rd_ptr    = 0;
      wr_ptr    = 0;
      count     = 0;
      need      = PKT_LEN_RST;
      pkt_cnt   = '0;
      due_q.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_START_BYTE) start_val = val;
      else if (idx == CFG_PACKET_LENGTH) len_reg = val[LEN_W-1:0];
    endfunction

    function int unsigned eff_len();
      if (len_reg < PKT_LEN_MIN) return PKT_LEN_MIN;
      if (len_reg > PKT_LEN_MAX) return PKT_LEN_MAX;
      return len_reg;
    endfunction

    function void push(logic [BYTE_W-1:0] data, logic valid, logic last, logic drop);
      ring_result_t r;
      r.data    = data;
      r.valid   = valid;
      r.last    = last;
      r.fill    = FILL_W'(count);
      r.pkts    = pkt_cnt;
      r.dropped = drop;
      due_q.push_back(r);
    endfunction

    // Frame a line byte or pop bytes for a host read; queue what the block must emit.
    function void absorb_item(logic req, logic [BYTE_W-1:0] rx, logic [RLEN_W-1:0] rlen);
      int unsigned len;
      int unsigned n;
      int unsigned i;
      logic drop;
      logic [BYTE_W-1:0] d;
      len = eff_len();
      if (req == REQ_BYTE) begin
        drop = 1'b0;
        if (need == 0 || need >= len) begin
          // hunting; also taken after a length change that leaves need out of range
          need = (rx == start_val) ? len - 1 : len;
        end else if (count < RING_DEPTH) begin
          ring[wr_ptr] = rx;
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          count++;
          need--;
          if (need == 0) begin
            pkt_cnt++;
            need = len;
          end
        end else begin
          drop = 1'b1;
        end
        push('0, 1'b0, 1'b1, drop);
      end else begin
        n = rlen;
        if (n > READ_CAP) n = READ_CAP;
        if (n > count) n = count;
        if (n == 0) begin
          push('0, 1'b0, 1'b1, 1'b0);
        end else begin
          for (i = 0; i < n; i++) begin
            d = ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            count--;
            push(d, 1'b1, (i + 1 == n), 1'b0);
          end
        end
      end
    endfunction

    function void check_field(string name, logic [FILL_W-1:0] exp, logic [FILL_W-1:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t exp;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual data %0d valid %0d last %0d",
                 $time, got.data, got.valid, got.last);
        mismatches++;
        return;
      end
      exp = due_q.pop_front();
      check_field("read_data", exp.data, got.data);
      check_field("read_valid", exp.valid, got.valid);
      check_field("last", exp.last, got.last);
      check_field("fill_level", exp.fill, got.fill);
      check_field("packets_done", exp.pkts, got.pkts);
      check_field("dropped", exp.dropped, got.dropped);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [BYTE_W-1:0]     in_rx_byte;
  logic [RLEN_W-1:0]     in_read_length;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_read_data;
  logic                  out_read_valid;
  logic                  out_last;
  logic [FILL_W-1:0]     out_fill_level;
  logic [PKT_CNT_W-1:0]  out_packets_done;
  logic                  out_dropped;

  ring_scoreboard sb;
  bit             calm;
  int unsigned    idle_cycles;

  serial_packet_receive_ring_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .in_read_length   (in_read_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid),
    .out_last         (out_last),
    .out_fill_level   (out_fill_level),
    .out_packets_done (out_packets_done),
    .out_dropped      (out_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [RLEN_W-1:0] pick_rlen();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RLEN_W'($urandom_range(READ_CAP + 1, 127));
      2:       return RLEN_W'(READ_CAP);
      default: return RLEN_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Transfer sampling, prediction, checking and the idle watchdog.
  always @(posedge clk) begin
    ring_result_t got;
    logic moved;
    if (!rst_n) begin
      sb.clear();
      idle_cycles = 0;
    end else begin
      moved = cfg_we;
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_stall === 1'b0) begin
        sb.absorb_item(in_req_type, in_rx_byte, in_read_length);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        got.data    = out_read_data;
        got.valid   = out_read_valid;
        got.last    = out_last;
        got.fill    = out_fill_level;
        got.pkts    = out_packets_done;
        got.dropped = out_dropped;
        sb.check_result(got);
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("[serial_packet_receive_ring_core] ERROR");
        $finish;
      end
    end
  end

  // Result side back-pressure: a random stall, possibly none, after each result transfer.
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) begin
        n = draw_wait();
        if (n != 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(input logic req, input logic [BYTE_W-1:0] rx,
                           input logic [RLEN_W-1:0] rlen);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_rx_byte     <= rx;
    in_read_length <= rlen;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] rx);
    send_item(REQ_BYTE, rx, RLEN_W'($urandom_range(0, 127)));
  endtask

  task automatic send_read(input logic [RLEN_W-1:0] rlen);
    send_item(REQ_READ, BYTE_W'($urandom_range(0, 255)), rlen);
  endtask

  // start byte followed by n payload bytes
  task automatic send_packet(input int unsigned n);
    send_byte(sb.start_val);
    repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_framing(input logic [CFG_DATA_W-1:0] start,
                             input logic [CFG_DATA_W-1:0] len);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_wdata <= start;
    @(negedge clk);
    cfg_index <= CFG_PACKET_LENGTH;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed packets, some cut short, plus reads and line noise.
  task automatic run_mixed(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = sb.eff_len();
          k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len - 1;
          send_packet(k);
          sent += k + 1;
        end
        6, 7, 8: begin
          send_read(pick_rlen());
          sent++;
        end
        default: begin
          send_byte(BYTE_W'($urandom_range(0, 255)));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    sb             = new();
    calm           = 1'b0;
    idle_cycles    = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_START_BYTE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_req_type    = REQ_BYTE;
    in_rx_byte     = '0;
    in_read_length = '0;
    sb.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset framing
    send_read(5);                     // empty store
    send_read(0);
    send_byte(8'h00);                 // ignored while hunting
    send_byte(8'hFF);
    send_byte(START_BYTE_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(START_BYTE_RST);        // start value as payload is stored
    send_byte(8'h01);
    send_byte(8'h80);
    send_read(0);                     // zero length with data held
    send_read(3);
    send_read(7'h7F);                 // capped, then limited by fill
    send_read(READ_CAP);
    send_byte(START_BYTE_RST);        // left mid-packet
    send_byte(8'h11);
    send_byte(8'h22);
    settle();
    // shorter length mid-packet: remaining count out of range, so it hunts again
    set_framing(8'hFF, 8'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h33);
    send_read(READ_CAP);
    settle();

    set_framing(8'h00, 8'd2);
    run_mixed(20);
    settle();

    set_framing(8'hFF, 8'd16);
    run_mixed(20);
    settle();

    set_framing(CFG_DATA_W'($urandom_range(0, 255)), 8'd31);   // clamps to 16
    run_mixed(25);
    settle();

    set_framing(CFG_DATA_W'($urandom_range(0, 255)), 8'd0);    // clamps to 2
    run_mixed(20);
    settle();

    set_framing(CFG_DATA_W'($urandom_range(0, 255)), 8'd1);
    run_mixed(20);
    settle();

    calm = 1'b1;
    set_framing(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(3, 15)));
    run_mixed(25);
    settle();
    calm = 1'b0;

    set_framing(START_BYTE_RST, PKT_LEN_RST);
    run_mixed(25);
    send_read(READ_CAP);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("[serial_packet_receive_ring_core] OK");
    end else begin
      $display("[serial_packet_receive_ring_core] ERROR");
    end
    $finish;
  end

endmodule
